// File: rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clk edge outside reset
`define SOPF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sopf assertion failed");

// Next-cycle implication, checked on every rising clk edge outside reset
`define SOPF_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sopf assertion failed");

`endif

// File: rtl/core/sopf_pkg.sv
`timescale 1ns / 1ps

package sopf_pkg;

  localparam int STATE_BITS   = 8;
  localparam int OFFSET_BITS  = 32;
  localparam int IDX_BITS     = 16;
  localparam int BYTE_BITS    = 8;
  localparam int MASK_BITS    = 8;
  localparam int OUT_OFF_BITS = 32;
  localparam int ENTRY_BITS   = 2 * STATE_BITS;

  localparam logic [STATE_BITS-1:0]  STATE_ONES = {STATE_BITS{1'b1}};
  localparam logic [ENTRY_BITS-1:0]  ENTRY_ONES = {ENTRY_BITS{1'b1}};
  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};
  localparam logic [IDX_BITS-1:0]    IDX_LAST   = {IDX_BITS{1'b1}};
  localparam logic [OFFSET_BITS-1:0] HINT_BACK  = OFFSET_BITS'(STATE_BITS);

  // Operation codes of the input op field
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_SCAN = 1'b1;

  // Table access request: one write or one read per cycle
  typedef struct packed {
    logic                  wr;
    logic                  rd;
    logic [IDX_BITS-1:0]   addr;
    logic [ENTRY_BITS-1:0] wdata;
  } tbl_req_t;

  // Fit an 8-bit mask field to the state width
  function automatic logic [STATE_BITS-1:0] fit_mask(input logic [MASK_BITS-1:0] m);
    logic [STATE_BITS+MASK_BITS-1:0] ext;
    ext = {{STATE_BITS{1'b0}}, m};
    return ext[STATE_BITS-1:0];
  endfunction

  // Fit an offset to the 32-bit result field
  function automatic logic [OUT_OFF_BITS-1:0] fit_off(input logic [OFFSET_BITS-1:0] v);
    logic [OFFSET_BITS+OUT_OFF_BITS-1:0] ext;
    ext = {{OUT_OFF_BITS{1'b0}}, v};
    return ext[OUT_OFF_BITS-1:0];
  endfunction

endpackage

// File: rtl/core/sopf_if.sv
`timescale 1ns / 1ps

// Input channel: load or scan transactions
interface sopf_in_if;
  logic                            valid;
  logic                            ready;
  logic                            op;
  logic [sopf_pkg::IDX_BITS-1:0]   table_index;
  logic [sopf_pkg::MASK_BITS-1:0]  start_mask;
  logic [sopf_pkg::MASK_BITS-1:0]  end_mask;
  logic [sopf_pkg::BYTE_BITS-1:0]  data_byte;
  logic                            first;
  logic                            last;

  modport source (output valid, op, table_index, start_mask, end_mask, data_byte, first, last,
                  input ready);
  modport sink (input valid, op, table_index, start_mask, end_mask, data_byte, first, last,
                output ready);
endinterface

// Result channel: one transaction per reported buffer
interface sopf_out_if;
  logic                              valid;
  logic                              ready;
  logic                              match;
  logic [sopf_pkg::OUT_OFF_BITS-1:0] match_offset;
  logic [sopf_pkg::OUT_OFF_BITS-1:0] hint_start;

  modport source (output valid, match, match_offset, hint_start, input ready);
  modport sink (input valid, match, match_offset, hint_start, output ready);
endinterface

// File: rtl/core/sopf_table.sv
`timescale 1ns / 1ps

module sopf_table (
  input  logic                            clk,
  input  logic                            rst_n,
  input  sopf_pkg::tbl_req_t              req,
  output logic                            busy,
  output logic [sopf_pkg::ENTRY_BITS-1:0] rd_data
);
  import sopf_pkg::*;

  // Entry layout: end mask in the upper half, position mask in the lower half
  logic [ENTRY_BITS-1:0] mem [0:(1 << IDX_BITS)-1];
  logic [ENTRY_BITS-1:0] rd_data_r;
  logic                  clearing_r, clearing_nxt;
  logic [IDX_BITS-1:0]   clr_idx_r, clr_idx_nxt;

  // Sweep every entry to all ones after reset
  always_comb begin
    clearing_nxt = clearing_r;
    clr_idx_nxt  = clr_idx_r;
    if (clearing_r) begin
      clr_idx_nxt = clr_idx_r + 1'b1;
      if (clr_idx_r == IDX_LAST) begin
        clearing_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_idx_r  <= '0;
    end else begin
      clearing_r <= clearing_nxt;
      clr_idx_r  <= clr_idx_nxt;
    end
  end

  // Single write port, registered read
  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_idx_r] <= ENTRY_ONES;
    end else if (req.wr) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd) begin
      rd_data_r <= mem[req.addr];
    end
  end

  assign busy    = clearing_r;
  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/shift_or_qgram_prefilter_top.sv
`timescale 1ns / 1ps

// Channel   Dir  Fields                                                       Accepted when
// in_ch     in   op, table_index, start_mask, end_mask, data_byte, first, last  valid && ready
// out_ch    out  match, match_offset, hint_start                                valid && ready
//
// One transaction per cycle while nothing stalls; a scan byte's result passes through the
// registered read of the 2-gram table and then the result register.
// After reset the table is swept to all ones; in_ch.ready stays low during the sweep.
// A held result stalls the match stage; input is still taken whenever that stage moves on.
// A load written in one cycle is seen by a scan byte taken in the next.

module shift_or_qgram_prefilter_top (
  input logic         clk,
  input logic         rst_n,
  sopf_in_if.sink     in_ch,
  sopf_out_if.source  out_ch
);
  import sopf_pkg::*;

  `include "assert_macros.svh"

  tbl_req_t              tbl_req;
  logic                  tbl_busy;
  logic [ENTRY_BITS-1:0] tbl_rd_data;

  sopf_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (tbl_req),
    .busy    (tbl_busy),
    .rd_data (tbl_rd_data)
  );

  // Front-end state: 2-gram tracking and offset
  logic [BYTE_BITS-1:0]   prev_r, prev_nxt;
  logic                   have_prev_r, have_prev_nxt;
  logic [OFFSET_BITS-1:0] off_r, off_nxt;

  // Match stage registers
  logic                   s1_valid_r, s1_valid_nxt;
  logic                   s1_first_r, s1_last_r, s1_gram_r;
  logic [OFFSET_BITS-1:0] s1_off_r, s1_hint_r;
  logic [STATE_BITS-1:0]  act_r, act_nxt;
  logic                   matched_r, matched_nxt;

  // Result register
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_match_r;
  logic [OUT_OFF_BITS-1:0] out_off_r, out_hint_r;

  logic                   in_acc, in_scan, s1_adv;
  logic                   hp_eff;
  logic [OFFSET_BITS-1:0] off_eff, off_inc, hint_eff;

  logic [STATE_BITS-1:0]  pos_m, end_m, act_eff, act_new;
  logic                   matched_eff, hit, res_valid, res_match;

  // Handshake
  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !tbl_busy && (!s1_valid_r || s1_adv);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_scan     = in_ch.op == OP_SCAN;

  // Front end: clear on first byte, form the 2-gram address
  always_comb begin
    hp_eff   = in_ch.first ? 1'b0 : have_prev_r;
    off_eff  = in_ch.first ? '0 : off_r;
    off_inc  = (off_eff == OFFSET_MAX) ? off_eff : off_eff + 1'b1;
    hint_eff = (off_eff >= HINT_BACK) ? off_eff - HINT_BACK : '0;

    tbl_req.wr    = in_acc && !in_scan;
    tbl_req.rd    = in_acc && in_scan;
    tbl_req.addr  = in_scan ? {in_ch.data_byte, prev_r} : in_ch.table_index;
    tbl_req.wdata = {fit_mask(in_ch.end_mask), fit_mask(in_ch.start_mask)};

    prev_nxt      = prev_r;
    have_prev_nxt = have_prev_r;
    off_nxt       = off_r;
    if (in_acc && in_scan) begin
      prev_nxt      = in_ch.data_byte;
      have_prev_nxt = 1'b1;
      off_nxt       = hp_eff ? off_inc : off_eff;
      if (in_ch.last) begin
        prev_nxt      = '0;
        have_prev_nxt = 1'b0;
        off_nxt       = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      have_prev_r <= 1'b0;
      off_r       <= '0;
    end else begin
      prev_r      <= prev_nxt;
      have_prev_r <= have_prev_nxt;
      off_r       <= off_nxt;
    end
  end

  // Hand a scan byte to the match stage
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc && in_scan) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_scan) begin
      s1_first_r <= in_ch.first;
      s1_last_r  <= in_ch.last;
      s1_gram_r  <= hp_eff;
      s1_off_r   <= off_eff;
      s1_hint_r  <= hint_eff;
    end
  end

  // Match stage: shift-or update and end test
  always_comb begin
    pos_m       = tbl_rd_data[STATE_BITS-1:0];
    end_m       = tbl_rd_data[ENTRY_BITS-1:STATE_BITS];
    act_eff     = s1_first_r ? STATE_ONES : act_r;
    matched_eff = s1_first_r ? 1'b0 : matched_r;
    act_new     = {act_eff[STATE_BITS-2:0], 1'b0} | pos_m;
    hit         = !matched_eff && s1_gram_r && ((act_new | end_m) != STATE_ONES);

    res_valid = hit || (s1_last_r && !matched_eff);
    res_match = hit;

    act_nxt     = act_r;
    matched_nxt = matched_r;
    if (s1_adv) begin
      act_nxt     = act_eff;
      matched_nxt = matched_eff || hit;
      if (!matched_eff && s1_gram_r) begin
        act_nxt = act_new;
      end
      if (s1_last_r) begin
        act_nxt     = STATE_ONES;
        matched_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r     <= STATE_ONES;
      matched_r <= 1'b0;
    end else begin
      act_r     <= act_nxt;
      matched_r <= matched_nxt;
    end
  end

  // Result register: load on a reporting byte, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv && res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res_valid) begin
      out_match_r <= res_match;
      out_off_r   <= res_match ? fit_off(s1_off_r) : '0;
      out_hint_r  <= res_match ? fit_off(s1_hint_r) : '0;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.match        = out_match_r;
  assign out_ch.match_offset = out_off_r;
  assign out_ch.hint_start   = out_hint_r;

  // No input is taken during the table sweep
  `SOPF_ASSERT_IMP(a_no_accept_in_sweep, tbl_busy, !in_ch.ready)
  // A stalled match stage keeps its byte
  `SOPF_ASSERT_NXT(a_s1_hold, s1_valid_r && !s1_adv, s1_valid_r)
  // A match inside a buffer blocks further reports until the buffer ends
  `SOPF_ASSERT_NXT(a_match_sticks, s1_adv && hit && !s1_last_r, matched_r)

endmodule
